// ===== design/wjvs_pkg.sv =====
// Shared types and constants for the weighted joint vertex skinning block.
`default_nettype none

package wjvs_pkg;

  localparam int COORD_W = 32;
  localparam int ROT_W   = 18;
  localparam int WEIGHT_W = 17;
  localparam int JIDX_W  = 7;
  localparam int PROD_W  = ROT_W + COORD_W;        // one rotation product
  localparam int PSUM_W  = PROD_W + 1;             // sum of three products
  localparam int T_W     = PSUM_W - 16 + 1;        // shifted row value plus translation
  localparam int WPROD_W = T_W + WEIGHT_W + 1;     // row value times weight
  localparam int DELTA_W = WPROD_W - 16;           // weighted contribution
  localparam int ACC_W   = 48;
  localparam int LANES   = 3;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_ADD   = 1'b1;

  localparam logic [1:0] KIND_POSITION = 2'd0;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ROT_W-1:0]   rot_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  // One transform row as stored in a lane's table.
  typedef struct packed {
    coord_t offset;
    rot_t   rz;
    rot_t   ry;
    rot_t   rx;
  } row_word_t;

  // Stage enables from the sequencer to every lane.
  typedef struct packed {
    logic rd_en;
    logic mul_en;
    logic sum_en;
    logic scale_en;
  } lane_ctrl_t;

  // Controls from the sequencer to the merging accumulator.
  typedef struct packed {
    logic acc_en;
    logic emit;
    logic add_ok;
  } acc_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SCALE,
    ST_ACC
  } state_t;

endpackage

`default_nettype wire

// ===== design/wjvs_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none

module wjvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/wjvs_lane.sv =====
// One transform row lane: row table, rotation multiply, row sum and weight scaling.
`default_nettype none

module wjvs_lane #(
  parameter int JOINT_COUNT = 128
) (
  input  wire logic                                              clk,
  input  wire wjvs_pkg::lane_ctrl_t                              ctrl,
  input  wire logic                                              wr_en,
  input  wire logic [((JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1)-1:0] waddr,
  input  wire wjvs_pkg::row_word_t                               wdata,
  input  wire logic [((JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1)-1:0] raddr,
  input  wire wjvs_pkg::coord_t                                  coord_x,
  input  wire wjvs_pkg::coord_t                                  coord_y,
  input  wire wjvs_pkg::coord_t                                  coord_z,
  input  wire logic [wjvs_pkg::WEIGHT_W-1:0]                     weight,
  input  wire logic                                              use_offset,
  output wjvs_pkg::delta_t                                       d
);

  import wjvs_pkg::*;

  localparam int ROW_W = $bits(row_word_t);

  logic [ROW_W-1:0]         ram_rdata;
  row_word_t                row;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  logic signed [PSUM_W-1:0] psum;
  logic signed [T_W-1:0]    t_next;
  logic signed [T_W-1:0]    t;
  logic signed [WPROD_W-1:0] wprod;

  wjvs_ram #(
    .WIDTH(ROW_W),
    .DEPTH(JOINT_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ctrl.rd_en),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  assign row = ram_rdata;

  // The row value is floored to Q16.16 before the translation is added.
  assign psum   = PSUM_W'(prod_x) + PSUM_W'(prod_y) + PSUM_W'(prod_z);
  assign t_next = T_W'($signed(psum[PSUM_W-1:16]))
                + (use_offset ? T_W'(row.offset) : T_W'(0));

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_x <= row.rx * coord_x;
      prod_y <= row.ry * coord_y;
      prod_z <= row.rz * coord_z;
    end
    if (ctrl.sum_en) begin
      t <= t_next;
    end
    if (ctrl.scale_en) begin
      wprod <= t * $signed({1'b0, weight});
    end
  end

  assign d = $signed(wprod[WPROD_W-1:16]);

endmodule

`default_nettype wire

// ===== design/wjvs_accum.sv =====
// Merging stage: saturating vector accumulator and output result register.
`default_nettype none

module wjvs_accum (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wjvs_pkg::acc_ctrl_t ctrl,
  input  wire wjvs_pkg::delta_t    d [wjvs_pkg::LANES],
  input  wire logic [1:0]          kind,
  output logic [1:0]               out_kind,
  output wjvs_pkg::coord_t         out_x,
  output wjvs_pkg::coord_t         out_y,
  output wjvs_pkg::coord_t         out_z,
  output logic                     saturated
);

  import wjvs_pkg::*;

  localparam int S_W = ACC_W + 1;

  logic signed [ACC_W-1:0] sum      [LANES];
  logic signed [S_W-1:0]   s        [LANES];
  logic signed [ACC_W-1:0] sum_next [LANES];
  coord_t                  emit_val [LANES];
  logic [LANES-1:0]        clip;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      s[i] = S_W'(sum[i]) + (ctrl.add_ok ? S_W'(d[i]) : S_W'(0));
      if (s[i][S_W-1] != s[i][ACC_W-1]) begin
        sum_next[i] = s[i][S_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        sum_next[i] = s[i][ACC_W-1:0];
      end
      // Clipping the 49-bit sum straight to 32 bits equals clipping it to 48 first.
      clip[i] = !((&s[i][S_W-1:COORD_W-1]) || !(|s[i][S_W-1:COORD_W-1]));
      if (clip[i]) begin
        emit_val[i] = s[i][S_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                  : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        emit_val[i] = s[i][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        sum[i] <= '0;
      end
    end else if (ctrl.acc_en) begin
      for (int i = 0; i < LANES; i++) begin
        sum[i] <= ctrl.emit ? '0 : sum_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_en && ctrl.emit) begin
      out_kind  <= kind;
      out_x     <= emit_val[0];
      out_y     <= emit_val[1];
      out_z     <= emit_val[2];
      saturated <= |clip;
    end
  end

endmodule

`default_nettype wire

// ===== design/weighted_joint_vertex_skinning_top.sv =====
// Top level of the weighted joint vertex skinning block: sequencer, three row lanes, merge.
`default_nettype none

// This block poses vertices by linear blend skinning in fixed point. A
// transfer with action 0 writes one row (three Q1.16 rotation entries,
// clipped to the 18-bit signed range, plus a Q16.16 translation) of the
// transform of one joint, and the next transfer can follow at once. A
// transfer with action 1 rotates its Q16.16 vector by the addressed joint,
// adds the translation for positions, scales by the unsigned Q1.16 weight
// and adds the result into a 48-bit saturating running sum. Each of the
// three transform rows has its own lane with its own row table, so the
// three output components are worked out side by side. A contribution
// reads the table at its transfer and then stalls the input through the
// rotation multiply, row sum, weight multiply and accumulate steps, which
// is the fixed sequence of the lanes. When the contribution carries the
// last flag, the sum is clipped to 32 bits, placed in the output register
// with a flag telling whether any component clipped, and cleared; the
// accumulate step waits only if a previous result is still stalled there.
// Joints at or above JOINT_COUNT are ignored on writes and add nothing on
// contributions; reading a row that was never written gives unspecified
// values.

module weighted_joint_vertex_skinning_top #(
  parameter int JOINT_COUNT = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic [wjvs_pkg::JIDX_W-1:0]   joint_index,
  input  wire logic [1:0]                    row_select,
  input  wire logic [1:0]                    vector_kind,
  input  wire logic [wjvs_pkg::WEIGHT_W-1:0] blend_weight,
  input  wire wjvs_pkg::coord_t              coord_x,
  input  wire wjvs_pkg::coord_t              coord_y,
  input  wire wjvs_pkg::coord_t              coord_z,
  input  wire wjvs_pkg::coord_t              row_offset,
  input  wire logic                          last_of_vertex,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_kind,
  output wjvs_pkg::coord_t                   out_x,
  output wjvs_pkg::coord_t                   out_y,
  output wjvs_pkg::coord_t                   out_z,
  output logic                               saturated
);

  import wjvs_pkg::*;

  localparam int AW   = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int JC_W = $clog2(JOINT_COUNT + 1);
  localparam int CMP_W = JC_W + JIDX_W;

  localparam logic signed [COORD_W-1:0] ROT_MAX = COORD_W'((1 <<< (ROT_W - 1)) - 1);
  localparam logic signed [COORD_W-1:0] ROT_MIN = -COORD_W'(1 <<< (ROT_W - 1));

  state_t     state;
  state_t     state_next;
  lane_ctrl_t lane_ctrl;
  acc_ctrl_t  acc_ctrl;

  logic                 in_fire;
  logic                 joint_ok;
  logic [AW+JIDX_W-1:0] joint_wide;
  logic [AW-1:0]        joint_addr;
  logic [LANES-1:0]     wr_en;
  row_word_t            wr_word;
  logic                 acc_go;
  logic                 out_load;
  logic                 out_valid_next;

  // Item held for the duration of a contribution.
  logic [1:0]          item_kind;
  logic [WEIGHT_W-1:0] item_weight;
  logic                item_last;
  logic                item_joint_ok;
  coord_t              item_x;
  coord_t              item_y;
  coord_t              item_z;

  delta_t lane_d [LANES];

  function automatic rot_t clamp_rot(input coord_t v);
    if (v > ROT_MAX) begin
      return ROT_MAX[ROT_W-1:0];
    end else if (v < ROT_MIN) begin
      return ROT_MIN[ROT_W-1:0];
    end else begin
      return v[ROT_W-1:0];
    end
  endfunction

  assign in_fire    = in_valid && !in_stall;
  assign joint_wide = {{AW{1'b0}}, joint_index};
  assign joint_addr = joint_wide[AW-1:0];
  assign joint_ok   = ({{JC_W{1'b0}}, joint_index} < CMP_W'(JOINT_COUNT));

  assign wr_word.rx     = clamp_rot(coord_x);
  assign wr_word.ry     = clamp_rot(coord_y);
  assign wr_word.rz     = clamp_rot(coord_z);
  assign wr_word.offset = row_offset;

  // Row three and out-of-range joints match no lane and are dropped.
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      wr_en[r] = in_fire && (action == ACTION_WRITE) && joint_ok
              && (row_select == 2'(r));
    end
  end

  // The accumulate step only waits when it must emit into an occupied,
  // stalled output register.
  assign acc_go   = !(item_last && out_valid && out_stall);
  assign out_load = acc_ctrl.acc_en && acc_ctrl.emit;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (action == ACTION_ADD)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_ACC;
      ST_ACC: begin
        if (acc_go) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // In the idle state the input is never stalled, so a valid contribution
  // is a transfer and starts the table read.
  always_comb begin
    in_stall           = 1'b1;
    lane_ctrl          = '0;
    acc_ctrl           = '0;
    acc_ctrl.emit      = item_last;
    acc_ctrl.add_ok    = item_joint_ok;
    case (state)
      ST_IDLE: begin
        in_stall        = 1'b0;
        lane_ctrl.rd_en = in_valid && (action == ACTION_ADD);
      end
      ST_MUL:   lane_ctrl.mul_en   = 1'b1;
      ST_SUM:   lane_ctrl.sum_en   = 1'b1;
      ST_SCALE: lane_ctrl.scale_en = 1'b1;
      ST_ACC:   acc_ctrl.acc_en    = acc_go;
      default:  in_stall           = 1'b1;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (action == ACTION_ADD)) begin
      item_kind     <= vector_kind;
      item_weight   <= blend_weight;
      item_last     <= last_of_vertex;
      item_joint_ok <= joint_ok;
      item_x        <= coord_x;
      item_y        <= coord_y;
      item_z        <= coord_z;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    wjvs_lane #(
      .JOINT_COUNT(JOINT_COUNT)
    ) u_lane (
      .clk       (clk),
      .ctrl      (lane_ctrl),
      .wr_en     (wr_en[g]),
      .waddr     (joint_addr),
      .wdata     (wr_word),
      .raddr     (joint_addr),
      .coord_x   (item_x),
      .coord_y   (item_y),
      .coord_z   (item_z),
      .weight    (item_weight),
      .use_offset(item_kind == KIND_POSITION),
      .d         (lane_d[g])
    );
  end

  wjvs_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (acc_ctrl),
    .d        (lane_d),
    .kind     (item_kind),
    .out_kind (out_kind),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .saturated(saturated)
  );

endmodule

`default_nettype wire

// ===== design/wjvs_checker.sv =====
// Port-level checker for the skinning block and its bind to the top level.
`default_nettype none

module wjvs_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     action,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [1:0]               out_kind,
  input wire wjvs_pkg::coord_t         out_x,
  input wire wjvs_pkg::coord_t         out_y,
  input wire wjvs_pkg::coord_t         out_z,
  input wire logic                     saturated
);

  import wjvs_pkg::*;

  // The block is ready right after reset.
  a_ready_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !in_stall)
    else $error("input stalled right after reset");

  // A contribution transfer stalls the input in the following cycle, while the lanes are busy.
  a_add_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == ACTION_ADD) |=> in_stall)
    else $error("input not stalled after a contribution transfer");

  // A row write finishes in the cycle it is taken.
  a_write_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == ACTION_WRITE) |=> !in_stall)
    else $error("input stalled after a row write transfer");

  // A new result only appears from the accumulate step of a contribution.
  a_result_from_acc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a contribution in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid
      && $stable({out_kind, out_x, out_y, out_z, saturated}))
    else $error("stalled result changed or was dropped");

endmodule

bind weighted_joint_vertex_skinning_top wjvs_checker u_checker (.*);

`default_nettype wire
